// ===== rtl/gzhp_pkg.sv =====
// Shared types, constants and section sequencing for the gzip header parser.
package gzhp_pkg;

  localparam logic [7:0] GZ_ID1       = 8'h1f;
  localparam logic [7:0] GZ_ID2       = 8'h8b;
  localparam logic [7:0] GZ_DEFLATE   = 8'h08;
  localparam logic [7:0] GZ_F_HCRC    = 8'h02;
  localparam logic [7:0] GZ_F_EXTRA   = 8'h04;
  localparam logic [7:0] GZ_F_NAME    = 8'h08;
  localparam logic [7:0] GZ_F_COMMENT = 8'h10;
  localparam logic [7:0] GZ_F_RESV    = 8'hE0;

  localparam logic [3:0] FIXED_LAST = 4'd9;

  typedef enum logic [2:0] {
    PH_FIXED,
    PH_XLEN,
    PH_XSKIP,
    PH_NAME,
    PH_COMMENT,
    PH_HCRC,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_MAGIC,
    ST_METHOD,
    ST_RESERVED,
    ST_PREMATURE
  } status_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  idx;
    logic [7:0]  flags;
    logic [31:0] mtime;
    logic [15:0] xrem;
    logic [31:0] total;
    status_t     fault;
  } state_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic [31:0] mtime;
    logic [7:0]  flags;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase: PH_FIXED,
    idx:   4'd0,
    flags: 8'd0,
    mtime: 32'd0,
    xrem:  16'd0,
    total: 32'd0,
    fault: ST_OK
  };

  // First optional section after 'after' whose flag is set, else PH_DONE.
  function automatic phase_t next_sec(input phase_t after, input logic [7:0] flags);
    phase_t ph;
    ph = PH_DONE;
    if (after < PH_HCRC && (flags & GZ_F_HCRC) != 8'd0) ph = PH_HCRC;
    if (after < PH_COMMENT && (flags & GZ_F_COMMENT) != 8'd0) ph = PH_COMMENT;
    if (after < PH_NAME && (flags & GZ_F_NAME) != 8'd0) ph = PH_NAME;
    if (after < PH_XLEN && (flags & GZ_F_EXTRA) != 8'd0) ph = PH_XLEN;
    return ph;
  endfunction

endpackage

// ===== rtl/gzhp_step.sv =====
// Per-byte next-state and result logic of the gzip header parser.
module gzhp_step (
  input  gzhp_pkg::state_t  cur,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output gzhp_pkg::state_t  nxt,
  output logic              emit,
  output gzhp_pkg::result_t res
);
  import gzhp_pkg::*;

  logic [15:0] xr;
  logic        adv;
  phase_t      after;
  phase_t      ph;
  status_t     st;

  always_comb begin
    nxt   = cur;
    emit  = 1'b0;
    st    = ST_OK;
    adv   = 1'b0;
    after = cur.phase;
    xr    = cur.xrem;
    ph    = PH_DONE;

    if (stream_end) begin
      emit = 1'b1;
      st   = ST_PREMATURE;
    end else begin
      if (cur.total != 32'hFFFF_FFFF) nxt.total = cur.total + 32'd1;

      case (cur.phase)
        PH_XLEN: begin
          if (cur.idx == 4'd0) begin
            nxt.xrem = {8'd0, data_byte};
            nxt.idx  = 4'd1;
          end else begin
            xr       = {data_byte, cur.xrem[7:0]};
            nxt.xrem = xr;
            if (xr != 16'd0) begin
              nxt.phase = PH_XSKIP;
            end else begin
              adv   = 1'b1;
              after = PH_XSKIP;
            end
          end
        end
        PH_XSKIP: begin
          xr       = cur.xrem - 16'd1;
          nxt.xrem = xr;
          if (xr == 16'd0) begin
            adv   = 1'b1;
            after = PH_XSKIP;
          end
        end
        PH_NAME, PH_COMMENT: begin
          if (data_byte == 8'd0) adv = 1'b1;
        end
        PH_HCRC: begin
          if (cur.idx == 4'd0) nxt.idx = 4'd1;
          else adv = 1'b1;
        end
        default: begin
          // fixed ten-byte header; first fault wins, reported after byte 9
          if (cur.idx == 4'd0 && data_byte != GZ_ID1 && cur.fault == ST_OK)
            nxt.fault = ST_MAGIC;
          else if (cur.idx == 4'd1 && data_byte != GZ_ID2 && cur.fault == ST_OK)
            nxt.fault = ST_MAGIC;
          else if (cur.idx == 4'd2 && data_byte != GZ_DEFLATE && cur.fault == ST_OK)
            nxt.fault = ST_METHOD;
          else if (cur.idx == 4'd3)
            nxt.flags = data_byte;
          else if (cur.idx >= 4'd4 && cur.idx <= 4'd7)
            nxt.mtime[{cur.idx[1:0], 3'b000} +: 8] = data_byte;

          if (cur.idx < FIXED_LAST) begin
            nxt.idx = cur.idx + 4'd1;
          end else if (cur.fault != ST_OK) begin
            emit = 1'b1;
            st   = cur.fault;
          end else if ((cur.flags & GZ_F_RESV) != 8'd0) begin
            emit = 1'b1;
            st   = ST_RESERVED;
          end else begin
            adv   = 1'b1;
            after = PH_FIXED;
          end
        end
      endcase

      if (adv) begin
        ph      = next_sec(after, nxt.flags);
        nxt.idx = 4'd0;
        if (ph == PH_DONE) begin
          emit = 1'b1;
          st   = ST_OK;
        end else begin
          nxt.phase = ph;
        end
      end
    end

    res.status = st;
    res.offset = nxt.total;
    res.mtime  = nxt.mtime;
    res.flags  = nxt.flags;

    if (emit) nxt = STATE_RESET;
  end

endmodule

// ===== rtl/gzhp_out_reg.sv =====
// Result holding register with stall handling.
module gzhp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  gzhp_pkg::result_t load_res,
  input  logic              out_stall,
  output logic              out_valid,
  output gzhp_pkg::result_t out_res,
  output logic              free
);
  import gzhp_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

// ===== rtl/gzip_header_parser.sv =====
// A byte is registered in the input register at accept and parsed from there once the
//   result register is free; a result beat is registered, then shows on out_valid.
// Throughput: one input beat per cycle unless held off by a stalled result.
// A stalled result holds the pipe only when the input register is also full.
// Reset (rst, synchronous, active high) clears the header state and both valids.
// Top level of the gzip member header parser.
module gzip_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] data_offset,
  output logic [31:0] mod_time,
  output logic [7:0]  header_flags
);
  import gzhp_pkg::*;

  // input register: one beat waiting to be parsed
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;

  // parser state, one update per parsed beat
  state_t  state;
  state_t  state_next;
  logic    emit;
  result_t step_res;
  result_t out_res;
  logic    out_free;
  logic    proc;

  // a beat is parsed whenever the result register can take what it may yield
  assign proc     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
      s1_end  <= stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (proc) begin
      state <= state_next;
    end
  end

  gzhp_step u_step (
    .cur        (state),
    .data_byte  (s1_byte),
    .stream_end (s1_end),
    .nxt        (state_next),
    .emit       (emit),
    .res        (step_res)
  );

  gzhp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (proc && emit),
    .load_res  (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .free      (out_free)
  );

  assign status       = out_res.status;
  assign data_offset  = out_res.offset;
  assign mod_time     = out_res.mtime;
  assign header_flags = out_res.flags;

endmodule

// ===== rtl/gzhp_checker.sv =====
// Port-level checks for the gzip header parser, bound to the top level.
module gzhp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [31:0] data_offset,
  input logic [31:0] mod_time,
  input logic [7:0]  header_flags
);
  import gzhp_pkg::*;

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_offset)
      && $stable(mod_time) && $stable(header_flags))
    else $error("stalled result beat changed");

  // input is held off only behind a stalled result beat
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // a fixed-header fault is always reported after exactly ten bytes
  a_fault_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_MAGIC || status == ST_METHOD || status == ST_RESERVED)
      |-> data_offset == 32'd10)
    else $error("fault beat with wrong offset");

  // a good header is at least the fixed part and has no reserved flag bits
  a_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> data_offset >= 32'd10 && header_flags[7:5] == 3'd0)
    else $error("ok beat inconsistent");

  // reserved-flag status only when a reserved bit is really set
  a_resv: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RESERVED |-> header_flags[7:5] != 3'd0)
    else $error("reserved status without reserved flags");

endmodule

bind gzip_header_parser gzhp_checker u_gzhp_checker (.*);
